// ===== rtl/d2i_pkg.sv =====
// Package: shared types and constants for the double to int32 converter.
`default_nettype none
package d2i_pkg;
    localparam logic [31:0] IndefiniteResult = 32'h8000_0000;
    localparam logic [30:0] MaxPositive = 31'h7fff_ffff;

    typedef enum logic [1:0] {
        RM_NEAREST = 2'd0,
        RM_DOWN    = 2'd1,
        RM_UP      = 2'd2,
        RM_ZERO    = 2'd3
    } t_round_mode;

    // stage 1 to stage 2 payload
    typedef struct packed {
        logic        special;  // result is already known
        logic [31:0] special_val;
        logic        sign;
        logic [52:0] sig;
        logic [5:0]  shift;    // right shift, 22..54 for non-special inputs
        t_round_mode mode;
    } t_dec;

    // stage 2 to stage 3 payload
    typedef struct packed {
        logic        special;
        logic [31:0] special_val;
        logic        sign;
        logic [30:0] ip;
        logic        inexact;
        logic        above_half;
        logic        at_half;
        t_round_mode mode;
    } t_aln;
endpackage
`default_nettype wire

// ===== rtl/d2i_decode.sv =====
// Stage 1: field split and special-case detection.
`default_nettype none
module d2i_decode import d2i_pkg::*; (
    input  wire logic [63:0] i_bits,
    input  wire logic        i_truncate,
    input  wire t_round_mode i_mode,
    output t_dec             o_dec
);
    logic [10:0] bexp;
    logic [51:0] frac;
    always_comb begin
        bexp = i_bits[62:52];
        frac = i_bits[51:0];
        o_dec.sign = i_bits[63];
        o_dec.mode = i_truncate ? RM_ZERO : i_mode;
        o_dec.special = 1'b0;
        o_dec.special_val = 32'd0;
        o_dec.sig = {(bexp != 11'd0), frac};
        if (bexp == 11'h7ff || bexp >= 11'd1054) begin
            o_dec.special = 1'b1;
            o_dec.special_val = IndefiniteResult;
        end else if (bexp == 11'd0 && frac == 52'd0) begin
            o_dec.special = 1'b1;
        end
        // r = 1075 - bexp (subnormal uses 1074); clamp to 54 meaning all fraction
        if (bexp == 11'd0)
            o_dec.shift = 6'd54;
        else if (bexp < 11'd1022)
            o_dec.shift = 6'd54;
        else
            o_dec.shift = 6'(11'd1075 - bexp);
    end
endmodule
`default_nettype wire

// ===== rtl/d2i_align.sv =====
// Stage 2: shift significand, form integer part and rounding flags.
`default_nettype none
module d2i_align import d2i_pkg::*; (
    input  wire t_dec  i_dec,
    output t_aln       o_aln
);
    logic [116:0] ext;
    logic [63:0]  rem;
    logic [63:0]  half;
    logic [63:0]  ipw;
    always_comb begin
        ext = {i_dec.sig, 64'd0} >> i_dec.shift;
        ipw = 64'(ext[116:64]);
        rem = ext[63:0];
        half = 64'h8000_0000_0000_0000;
        o_aln.special = i_dec.special;
        o_aln.special_val = i_dec.special_val;
        o_aln.sign = i_dec.sign;
        o_aln.mode = i_dec.mode;
        o_aln.ip = ipw[30:0];
        o_aln.inexact = (rem != 64'd0);
        if (i_dec.shift == 6'd54) begin
            o_aln.above_half = 1'b0;
            o_aln.at_half = 1'b0;
        end else begin
            o_aln.above_half = rem > half;
            o_aln.at_half = rem == half;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/d2i_round.sv =====
// Stage 3: range check, rounding increment and sign application.
`default_nettype none
module d2i_round import d2i_pkg::*; (
    input  wire t_aln        i_aln,
    output logic [31:0]      o_result
);
    logic        inc;
    logic [31:0] mag;
    always_comb begin
        case (i_aln.mode)
            RM_NEAREST: inc = i_aln.above_half || (i_aln.at_half && i_aln.ip[0]);
            RM_DOWN:    inc = i_aln.sign && i_aln.inexact;
            RM_UP:      inc = !i_aln.sign && i_aln.inexact;
            default:    inc = 1'b0;
        endcase
        mag = {1'b0, i_aln.ip} + {31'd0, inc};
        if (i_aln.special)
            o_result = i_aln.special_val;
        else if (!i_aln.sign && i_aln.ip == MaxPositive && i_aln.inexact)
            o_result = IndefiniteResult;
        else if (i_aln.sign)
            o_result = 32'd0 - mag;
        else
            o_result = mag;
    end
endmodule
`default_nettype wire

// ===== rtl/double_to_int32_convert_core.sv =====
// Top level: three-stage pipelined binary64 to int32 converter.
// Register stages: 3 (decode, align, round); each stage's output is registered before
// the next stage, and the round stage register drives m_axis_tdata.
// Throughput: one item per cycle while m_axis_tready is high; a stall holds each occupied stage.
// Reset (synchronous, active low) clears stage valids and sets rounding mode to nearest-even.
`default_nettype none
module double_to_int32_convert_core import d2i_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,  // value_bits
    input  wire logic        s_axis_tuser,  // truncate
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata   // int_result
);
    t_round_mode r_mode;
    logic        r_v1, r_v2, r_v3;
    t_dec        r_dec, n_dec;
    t_aln        r_aln, n_aln;
    logic [31:0] r_res, n_res;
    logic        adv3, adv2, adv1;

    assign o_cfg_ready = 1'b1;
    assign adv3 = !r_v3 || m_axis_tready;
    assign adv2 = !r_v2 || adv3;
    assign adv1 = !r_v1 || adv2;
    assign s_axis_tready = adv1;
    assign m_axis_tvalid = r_v3;
    assign m_axis_tdata = r_res;

    d2i_decode u_dec (.i_bits(s_axis_tdata), .i_truncate(s_axis_tuser),
                      .i_mode(r_mode), .o_dec(n_dec));
    d2i_align  u_aln (.i_dec(r_dec), .o_aln(n_aln));
    d2i_round  u_rnd (.i_aln(r_aln), .o_result(n_res));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= RM_NEAREST;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (i_cfg_valid) r_mode <= t_round_mode'(i_cfg_data);
            if (adv1) r_v1 <= s_axis_tvalid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) r_dec <= n_dec;
        if (adv2) r_aln <= n_aln;
        if (adv3) r_res <= n_res;
    end
endmodule
`default_nettype wire
